>>> rtl/lrupf_pkg.sv
// Package: shared constants and types of the LRU page frame replacement unit.
package lrupf_pkg;

    localparam int FRAMES      = 16;
    localparam int IDX_W       = $clog2(FRAMES);
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(FRAMES + 1);
    localparam int PID_W       = 8;
    localparam int PAGE_W      = 16;
    localparam int ENTRY_W     = PID_W + PAGE_W;
    localparam int FIU_W       = 5;
    localparam int FRAME_OUT_W = 4;
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    // One frame as seen by the scan unit
    typedef struct packed {
        logic              step;
        logic              used;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
        logic [PID_W-1:0]  owner;
        logic [PAGE_W-1:0] page;
        logic              below_lim;
    } scan_entry_t;

    // Summary of a full walk over the frame table
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              found;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              have_vic;
        logic [IDX_W-1:0]  vic_idx;
        logic [RANK_W-1:0] vic_rank;
        logic [PID_W-1:0]  vic_owner;
        logic [PAGE_W-1:0] vic_page;
        logic              have_free;
        logic [IDX_W-1:0]  free_idx;
    } scan_res_t;

endpackage

>>> rtl/lrupf_if.sv
// Interfaces: page reference channel and result channel.
interface lrupf_in_if;
    import lrupf_pkg::*;

    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output process_id, output page_number, input ready);
    modport sink   (input valid, input process_id, input page_number, output ready);
endinterface

interface lrupf_out_if;
    import lrupf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted;
    logic [PID_W-1:0]       evicted_process;
    logic [PAGE_W-1:0]      evicted_page;

    modport source (output valid, output hit, output frame_index, output evicted,
                    output evicted_process, output evicted_page, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted,
                    input evicted_process, input evicted_page, output ready);
endinterface

>>> rtl/lrupf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrupf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/lrupf_scan.sv
// Scan unit: one tag/rank comparator that accumulates hit, victim and free frame.
module lrupf_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrupf_pkg::PID_W-1:0]  pid,
    input  logic [lrupf_pkg::PAGE_W-1:0] pg,
    input  lrupf_pkg::scan_entry_t       entry,
    output lrupf_pkg::scan_res_t         res
);
    import lrupf_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      tag_eq;
    logic      rank_gt;

    assign tag_eq  = entry.used && (entry.owner == pid) && (entry.page == pg);
    assign rank_gt = !res_reg.have_vic || (entry.rank > res_reg.vic_rank);

    always_comb
    begin
        res_next = res_reg;
        if (entry.step)
        begin
            if (entry.used)
            begin
                res_next.count = res_reg.count + CNT_W'(1);
            end
            if (tag_eq && !res_reg.found)
            begin
                res_next.found    = 1'b1;
                res_next.hit_idx  = entry.idx;
                res_next.hit_rank = entry.rank;
            end
            if (entry.used && rank_gt)
            begin
                res_next.have_vic  = 1'b1;
                res_next.vic_idx   = entry.idx;
                res_next.vic_rank  = entry.rank;
                res_next.vic_owner = entry.owner;
                res_next.vic_page  = entry.page;
            end
            if (!entry.used && entry.below_lim && !res_reg.have_free)
            begin
                res_next.have_free = 1'b1;
                res_next.free_idx  = entry.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (start)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/lru_page_frame_replacement_unit.sv
// Top level: LRU page frame replacement unit with sequencer, frame table and result register.
// Each page reference passes through the states IDLE, SCAN, DRAIN and UPDATE: the
// sequencer walks the owner/page RAM one frame per cycle through a single comparator,
// then drains the RAM read in DRAIN and updates valid bits, recency ranks and the RAM
// in UPDATE, which waits while the output register still holds an untaken result. The
// result is held in an output register, so the next reference can start while it waits.
// Writing frames_in_use frees every frame; a value of 0 acts as 1 and values above
// FRAMES act as FRAMES.
module lru_page_frame_replacement_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lrupf_pkg::FIU_W-1:0] cfg_wdata,
    lrupf_in_if.sink                    in_ch,
    lrupf_out_if.source                 out_ch
);
    import lrupf_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [FIU_W-1:0]   fiu_reg;
    logic [CNT_W-1:0]   lim;
    logic [PID_W-1:0]   pid_reg;
    logic [PAGE_W-1:0]  pg_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               pv_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [FRAMES-1:0]  valid_reg;
    logic [FRAMES-1:0]  valid_next;
    logic [RANK_W-1:0]  rank_reg  [FRAMES];
    logic [RANK_W-1:0]  rank_next [FRAMES];
    logic               accept;
    logic               upd_fire;
    logic               evict;
    logic [IDX_W-1:0]   slot;
    logic [ENTRY_W-1:0] rd_data;
    scan_entry_t        entry;
    scan_res_t          res;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [FRAME_OUT_W-1:0] out_frame_reg;
    logic               out_ev_reg;
    logic [PID_W-1:0]   out_evp_reg;
    logic [PAGE_W-1:0]  out_evg_reg;

    // Effective frame limit
    always_comb
    begin
        if (32'(fiu_reg) > FRAMES)
        begin
            lim = CNT_W'(FRAMES);
        end
        else if (fiu_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else
        begin
            lim = CNT_W'(fiu_reg);
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign upd_fire    = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_W'(FRAMES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fiu_reg   <= FIU_RESET;
            pv_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == ST_SCAN);
            if (cfg_we)
            begin
                fiu_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= cnt_reg;
        if (accept)
        begin
            pid_reg <= in_ch.process_id;
            pg_reg  <= in_ch.page_number;
        end
    end

    lrupf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (upd_fire && !res.found),
        .waddr (slot),
        .wdata ({pid_reg, pg_reg}),
        .re    (state_reg == ST_SCAN),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        entry.step      = pv_reg;
        entry.used      = valid_reg[pidx_reg];
        entry.idx       = pidx_reg;
        entry.rank      = rank_reg[pidx_reg];
        entry.owner     = rd_data[ENTRY_W-1:PAGE_W];
        entry.page      = rd_data[PAGE_W-1:0];
        entry.below_lim = (CNT_W'(pidx_reg) < lim);
    end

    lrupf_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .pid   (pid_reg),
        .pg    (pg_reg),
        .entry (entry),
        .res   (res)
    );

    // Replacement decision and table update
    assign evict = !res.found && (res.count >= lim) && res.have_vic;

    always_comb
    begin
        if (res.found)
        begin
            slot = res.hit_idx;
        end
        else if (evict && (!res.have_free || (res.vic_idx < res.free_idx)))
        begin
            slot = res.vic_idx;
        end
        else if (res.have_free)
        begin
            slot = res.free_idx;
        end
        else
        begin
            slot = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
            if (res.found)
            begin
                if (valid_reg[i] && (rank_reg[i] < res.hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else
            begin
                if (evict && (res.vic_idx == IDX_W'(i)))
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (slot == IDX_W'(i))
            begin
                valid_next[i] = 1'b1;
                rank_next[i]  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cfg_we)
        begin
            valid_reg <= '0;
        end
        else if (upd_fire)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            rank_reg <= rank_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            out_hit_reg   <= res.found;
            out_frame_reg <= FRAME_OUT_W'(slot);
            out_ev_reg    <= evict;
            out_evp_reg   <= evict ? res.vic_owner : '0;
            out_evg_reg   <= evict ? res.vic_page : '0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.hit             = out_hit_reg;
    assign out_ch.frame_index     = out_frame_reg;
    assign out_ch.evicted         = out_ev_reg;
    assign out_ch.evicted_process = out_evp_reg;
    assign out_ch.evicted_page    = out_evg_reg;

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.evicted |-> !out_ch.hit)
        else $error("eviction reported on a hit");

    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.evicted |->
            (out_ch.evicted_process == '0) && (out_ch.evicted_page == '0))
        else $error("evicted identity nonzero without eviction");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("transfer did not start a scan");

    a_resident_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= int'(lim))
        else $error("resident pages exceed frame limit");

endmodule
